@@ sv/tls_client_hello_sni_locator_macros.svh @@
// Assertion macros used by the server-name locator parser.
`ifndef TLS_CLIENT_HELLO_SNI_LOCATOR_MACROS_SVH
`define TLS_CLIENT_HELLO_SNI_LOCATOR_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TSNI_ASSERT_SAME(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
		(ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TSNI_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
		(ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tsni_pkg.sv @@
// Package: constants and types shared by the server-name locator.
`timescale 1ns / 1ps
`default_nettype none
package tsni_pkg;

	// Default largest payload that is parsed
	localparam int MAX_PAYLOAD_DEF = 65535;

	// Width of stream positions
	localparam int POS_W = 18;

	// Record and handshake codes
	localparam logic [7:0] REC_HANDSHAKE   = 8'h16;
	localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
	localparam logic [7:0] NAME_HOST       = 8'h00;
	localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;

	// Fixed header offsets
	localparam logic [POS_W-1:0] POS_REC_TYPE = POS_W'(0);
	localparam logic [POS_W-1:0] POS_HS_TYPE  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_HEAD_END = POS_W'(42);

	// Minimum server-name extension body and its list-length prefix
	localparam logic [POS_W-1:0] SNI_MIN_LEN  = POS_W'(5);
	localparam logic [POS_W-1:0] SNI_LIST_LEN = POS_W'(2);
	localparam logic [POS_W:0]   EXT_HDR_LEN  = (POS_W+1)'(4);

	// One result request
	typedef struct packed {
		logic        found;
		logic [15:0] name_offset;
		logic [15:0] name_length;
	} result_t;

endpackage
`default_nettype wire

@@ sv/tsni_in_reg.sv @@
// Input register: holds one byte request until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module tsni_in_reg
	import tsni_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       res_free,
	output logic            step,
	output logic [7:0]      byte_s1,
	output logic            last_s1
);

	logic valid_s1;

	// Advance unless a final byte must wait for the result slot
	assign step     = valid_s1 && (!last_s1 || res_free);
	assign in_ready = !valid_s1 || step;

	// Hold valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

endmodule
`default_nettype wire

@@ sv/tsni_parser.sv @@
// Parser: walks the ClientHello one byte per step and forms the result.
`timescale 1ns / 1ps
`default_nettype none
`include "tls_client_hello_sni_locator_macros.svh"
module tsni_parser
	import tsni_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_s1,
	input  wire logic       last_s1,
	output logic            res_valid,
	output result_t         res
);

	localparam int CW = $clog2(MAX_PAYLOAD + 2);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAYLOAD);

	typedef enum logic [3:0] {
		PH_HEAD, PH_SID, PH_CS_HI, PH_CS_LO, PH_COMP, PH_XL_HI, PH_XL_LO,
		PH_ET_HI, PH_ET_LO, PH_EL_HI, PH_EL_LO, PH_SN_TYPE, PH_SN_HI,
		PH_SN_LO, PH_DONE
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [CW-1:0]     count_q, count_n;
	logic [POS_W-1:0]  nfp_q, nfp_n;
	logic [POS_W-1:0]  xend_q, xend_n;
	logic [POS_W-1:0]  eend_q, eend_n;
	logic [7:0]        shift_q, shift_n;
	logic              sni_q, sni_n;
	logic [15:0]       cand_off_q, cand_off_n;
	logic [15:0]       cand_len_q, cand_len_n;
	logic              cand_q, cand_n;
	logic              failed_q, failed_n;

	logic [15:0]       word;
	logic [POS_W-1:0]  pos;
	logic [POS_W-1:0]  after;
	logic [POS_W-1:0]  new_end;
	logic              take;
	logic              ok;

	// Work out the next parse state for the byte at the input register
	always_comb begin
		word       = {shift_q, byte_s1};
		pos        = POS_W'(count_q);
		after      = pos + POS_W'(1);
		new_end    = after + POS_W'(word);
		take       = (count_q < CNT_MAX) && (phase_q != PH_DONE) && (pos == nfp_q);
		count_n    = (count_q <= CNT_MAX) ? count_q + CW'(1) : count_q;
		phase_n    = phase_q;
		nfp_n      = nfp_q;
		xend_n     = xend_q;
		eend_n     = eend_q;
		shift_n    = shift_q;
		sni_n      = sni_q;
		cand_off_n = cand_off_q;
		cand_len_n = cand_len_q;
		cand_n     = cand_q;
		failed_n   = failed_q;
		if (take) begin
			nfp_n = after;
			case (phase_q)
				PH_HEAD: begin
					if ((pos == POS_REC_TYPE && byte_s1 != REC_HANDSHAKE) ||
					    (pos == POS_HS_TYPE && byte_s1 != HS_CLIENT_HELLO)) begin
						failed_n = 1'b1;
						phase_n  = PH_DONE;
					end else if (pos == POS_HEAD_END) begin
						phase_n = PH_SID;
					end
				end
				PH_SID: begin
					nfp_n   = after + POS_W'(byte_s1);
					phase_n = PH_CS_HI;
				end
				PH_CS_HI: begin
					shift_n = byte_s1;
					phase_n = PH_CS_LO;
				end
				PH_CS_LO: begin
					nfp_n   = new_end;
					phase_n = PH_COMP;
				end
				PH_COMP: begin
					nfp_n   = after + POS_W'(byte_s1);
					phase_n = PH_XL_HI;
				end
				PH_XL_HI: begin
					shift_n = byte_s1;
					phase_n = PH_XL_LO;
				end
				PH_XL_LO: begin
					xend_n = new_end;
					if ({1'b0, after} + EXT_HDR_LEN > {1'b0, new_end}) begin
						failed_n = 1'b1;
						phase_n  = PH_DONE;
					end else begin
						phase_n = PH_ET_HI;
					end
				end
				PH_ET_HI: begin
					shift_n = byte_s1;
					phase_n = PH_ET_LO;
				end
				PH_ET_LO: begin
					sni_n   = (word == EXT_SERVER_NAME);
					phase_n = PH_EL_HI;
				end
				PH_EL_HI: begin
					shift_n = byte_s1;
					phase_n = PH_EL_LO;
				end
				PH_EL_LO: begin
					eend_n = new_end;
					if (new_end > xend_q) begin
						failed_n = 1'b1;
						phase_n  = PH_DONE;
					end else if (sni_q) begin
						if (after + SNI_MIN_LEN > new_end) begin
							failed_n = 1'b1;
							phase_n  = PH_DONE;
						end else begin
							nfp_n   = after + SNI_LIST_LEN;
							phase_n = PH_SN_TYPE;
						end
					end else begin
						// skip the whole extension
						nfp_n = new_end;
						if ({1'b0, new_end} + EXT_HDR_LEN > {1'b0, xend_q}) begin
							failed_n = 1'b1;
							phase_n  = PH_DONE;
						end else begin
							phase_n = PH_ET_HI;
						end
					end
				end
				PH_SN_TYPE: begin
					if (byte_s1 == NAME_HOST) begin
						phase_n = PH_SN_HI;
					end else begin
						// other name type: move on to the next extension
						nfp_n = eend_q;
						if ({1'b0, eend_q} + EXT_HDR_LEN > {1'b0, xend_q}) begin
							failed_n = 1'b1;
							phase_n  = PH_DONE;
						end else begin
							phase_n = PH_ET_HI;
						end
					end
				end
				PH_SN_HI: begin
					shift_n = byte_s1;
					phase_n = PH_SN_LO;
				end
				PH_SN_LO: begin
					if (new_end > eend_q) begin
						failed_n = 1'b1;
						phase_n  = PH_DONE;
					end else begin
						cand_off_n = after[15:0];
						cand_len_n = word;
						cand_n     = 1'b1;
						phase_n    = PH_DONE;
					end
				end
				default: begin
					phase_n = PH_DONE;
				end
			endcase
		end
		ok = cand_n && !failed_n && (count_n <= CNT_MAX) && (xend_n <= POS_W'(count_n));
	end

	// Result on the final byte
	assign res_valid       = step && last_s1;
	assign res.found       = ok;
	assign res.name_offset = ok ? cand_off_n : 16'd0;
	assign res.name_length = ok ? cand_len_n : 16'd0;

	// Hold parse state; drop it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEAD;
			count_q    <= '0;
			nfp_q      <= '0;
			xend_q     <= '0;
			eend_q     <= '0;
			shift_q    <= '0;
			sni_q      <= 1'b0;
			cand_off_q <= '0;
			cand_len_q <= '0;
			cand_q     <= 1'b0;
			failed_q   <= 1'b0;
		end else if (step) begin
			if (last_s1) begin
				phase_q    <= PH_HEAD;
				count_q    <= '0;
				nfp_q      <= '0;
				xend_q     <= '0;
				eend_q     <= '0;
				shift_q    <= '0;
				sni_q      <= 1'b0;
				cand_off_q <= '0;
				cand_len_q <= '0;
				cand_q     <= 1'b0;
				failed_q   <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				count_q    <= count_n;
				nfp_q      <= nfp_n;
				xend_q     <= xend_n;
				eend_q     <= eend_n;
				shift_q    <= shift_n;
				sni_q      <= sni_n;
				cand_off_q <= cand_off_n;
				cand_len_q <= cand_len_n;
				cand_q     <= cand_n;
				failed_q   <= failed_n;
			end
		end
	end

	`TSNI_ASSERT_NEXT(a_restart, clk, arst_n, step && last_s1, (phase_q == PH_HEAD) && (count_q == '0), "parser did not restart after final byte")
	`TSNI_ASSERT_SAME(a_found_off, clk, arst_n, res_valid && res.found, res.name_offset > 16'(POS_HEAD_END), "name offset inside fixed header")
	`TSNI_ASSERT_SAME(a_cand_ok, clk, arst_n, cand_q, !failed_q && (phase_q == PH_DONE), "candidate held while parse still open")
	`TSNI_ASSERT_NEXT(a_done_stays, clk, arst_n, step && !last_s1 && (phase_q == PH_DONE), phase_q == PH_DONE, "parser left done phase mid payload")

endmodule
`default_nettype wire

@@ sv/tsni_out_reg.sv @@
// Result register: holds one result request until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module tsni_out_reg
	import tsni_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  result_t   res,
	output logic      res_free,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      found,
	output logic [15:0] name_offset,
	output logic [15:0] name_length
);

	logic    valid_q;
	result_t res_q;

	assign res_free    = !valid_q || out_ready;
	assign out_valid   = valid_q;
	assign found       = res_q.found;
	assign name_offset = res_q.name_offset;
	assign name_length = res_q.name_length;

	// Hold valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_free) begin
			valid_q <= load;
		end
	end

	// Capture result
	always_ff @(posedge clk) begin
		if (load && res_free) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

@@ sv/tls_client_hello_sni_locator.sv @@
// Top level of the ClientHello server-name locator.
// Input channel: one payload byte a request (data_byte, last_byte on the
//   final byte) with in_valid / in_ready.
// Output channel: one result request a payload (found, name_offset,
//   name_length) with out_valid / out_ready, raised only for the final byte.
// Throughput: one byte a cycle unless a final byte waits for the result
//   register; the byte register and the parse state step once per cycle.
// Result path: the final byte is taken into the input register, the
//   parser works on it there, and the result register loads the result
//   when the parser steps; out_valid is that register's valid flag.
// Offsets and lengths come from the stream position counter; payloads of
//   more than MAX_PAYLOAD bytes report not found.
// Reset: arst_n clears the parse state and both valid flags; the next byte
//   taken is offset zero of a new payload.
// Stall: while out_ready is low a held result blocks only a further final
//   byte; ordinary bytes keep streaming into the parser.
`timescale 1ns / 1ps
`default_nettype none
module tls_client_hello_sni_locator
	import tsni_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [15:0]      name_offset,
	output logic [15:0]      name_length
);

	logic       step;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       res_free;
	logic       res_valid;
	result_t    res;

	tsni_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res_free  (res_free),
		.step      (step),
		.byte_s1   (byte_s1),
		.last_s1   (last_s1)
	);

	tsni_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.last_s1   (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	tsni_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (res_valid),
		.res         (res),
		.res_free    (res_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.name_offset (name_offset),
		.name_length (name_length)
	);

endmodule
`default_nettype wire
